// ----- design/rectangle_subtract_top_defines.svh -----
// ----------------------------------------------------------------------------
// rectangle_subtract_top_defines.svh
// assertion macros shared by the rectangle subtract design
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_SUBTRACT_TOP_DEFINES_SVH
`define RECTANGLE_SUBTRACT_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RSUB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rsub: same-cycle check failed");

// next-cycle implication, checked out of reset
`define RSUB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rsub: next-cycle check failed");

`endif

// ----- design/rsub_pkg.sv -----
// ----------------------------------------------------------------------------
// rsub_pkg
// shared types and constants of the rectangle subtract block
// ----------------------------------------------------------------------------
package rsub_pkg;

	// number of remainder strips around the cut
	localparam int NUM_STRIPS = 4;

	// strip order on the result channel
	typedef enum logic [1:0] {
		STRIP_TOP    = 2'd0,
		STRIP_LEFT   = 2'd1,
		STRIP_BOTTOM = 2'd2,
		STRIP_RIGHT  = 2'd3
	} strip_t;

	typedef logic [NUM_STRIPS-1:0] strip_mask_t;

endpackage

// ----- design/rsub_if.sv -----
// ----------------------------------------------------------------------------
// rsub_if
// valid/ready channels of the rectangle subtract block
// ----------------------------------------------------------------------------

// rectangle pair channel: cut rectangle and target rectangle
interface rsub_rect_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] cut_left;
	logic signed [COORD_WIDTH-1:0] cut_top;
	logic signed [COORD_WIDTH-1:0] cut_right;
	logic signed [COORD_WIDTH-1:0] cut_bottom;
	logic signed [COORD_WIDTH-1:0] target_left;
	logic signed [COORD_WIDTH-1:0] target_top;
	logic signed [COORD_WIDTH-1:0] target_right;
	logic signed [COORD_WIDTH-1:0] target_bottom;

	modport source (
		output valid, cut_left, cut_top, cut_right, cut_bottom,
		output target_left, target_top, target_right, target_bottom,
		input  ready
	);
	modport sink (
		input  valid, cut_left, cut_top, cut_right, cut_bottom,
		input  target_left, target_top, target_right, target_bottom,
		output ready
	);
endinterface

// piece channel: one remaining piece per transaction
interface rsub_piece_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] piece_left;
	logic signed [COORD_WIDTH-1:0] piece_top;
	logic signed [COORD_WIDTH-1:0] piece_right;
	logic signed [COORD_WIDTH-1:0] piece_bottom;
	logic                          piece_valid;
	logic                          last_piece;

	modport source (
		output valid, piece_left, piece_top, piece_right, piece_bottom,
		output piece_valid, last_piece,
		input  ready
	);
	modport sink (
		input  valid, piece_left, piece_top, piece_right, piece_bottom,
		input  piece_valid, last_piece,
		output ready
	);
endinterface

// ----- design/rectangle_subtract_top.sv -----
// path: an accepted pair passes stages s1, s2, s3, then the serializer registers
// throughput: one piece per cycle while pieces.ready is high; a pair yields
// 1 to 4 pieces, sent by the single-entry piece serializer after three stages
// reset: arst_n clears all stage valids and the serializer, payload is not reset
// ----------------------------------------------------------------------------
// rectangle_subtract_top
// removes a cut rectangle from a target rectangle and streams the remaining
// strips (top, left, bottom, right) one transaction each
// ----------------------------------------------------------------------------
`include "rectangle_subtract_top_defines.svh"

module rectangle_subtract_top #(
	parameter int COORD_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	rsub_rect_if.sink    rects,
	rsub_piece_if.source pieces
);
	import rsub_pkg::*;

	localparam int W = COORD_WIDTH;

	typedef logic signed [W-1:0] crd_t;
	typedef logic signed [W:0]   crdx_t;

	// ------------------------------------------------------------------------
	// stage registers
	// ------------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3, ser_rdy;

	// stage 1: captured coordinates
	crd_t cl_s1, ct_s1, cr_s1, cb_s1, tl_s1, tt_s1, tr_s1, tb_s1;

	// stage 2: widened coordinates, shifted edges, intersection
	crdx_t cl_s2, ct_s2, cr_s2, cb_s2, tl_s2, tt_s2, tr_s2, tb_s2;
	crdx_t ctm1_s2, cbp1_s2, clm1_s2, crp1_s2;
	crdx_t xl_s2, xt_s2, xr_s2, xb_s2;

	// stage 3: emptiness decisions and narrowed strip bounds
	logic        pass_s3;
	strip_mask_t keep_s3;
	crd_t        tl_s3, tt_s3, tr_s3, tb_s3;
	crd_t        ctm1_s3, cbp1_s3, clm1_s3, crp1_s3, xt_s3, xb_s3;

	// serializer registers
	logic        ser_vld_q;
	logic        pass_q, none_q;
	strip_mask_t mask_q;
	crd_t        tl_q, tt_q, tr_q, tb_q;
	crd_t        ctm1_q, cbp1_q, clm1_q, crp1_q, xt_q, xb_q;

	// ------------------------------------------------------------------------
	// backpressure chain
	// ------------------------------------------------------------------------
	logic   last_w;
	strip_t sel_w;

	assign ser_rdy     = !ser_vld_q || (pieces.ready && last_w);
	assign rdy_s3      = !vld_s3 || ser_rdy;
	assign rdy_s2      = !vld_s2 || rdy_s3;
	assign rdy_s1      = !vld_s1 || rdy_s2;
	assign rects.ready = rdy_s1;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= rects.valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	// ------------------------------------------------------------------------
	// stage 1: capture
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (rdy_s1 && rects.valid) begin
			cl_s1 <= rects.cut_left;
			ct_s1 <= rects.cut_top;
			cr_s1 <= rects.cut_right;
			cb_s1 <= rects.cut_bottom;
			tl_s1 <= rects.target_left;
			tt_s1 <= rects.target_top;
			tr_s1 <= rects.target_right;
			tb_s1 <= rects.target_bottom;
		end
	end

	// ------------------------------------------------------------------------
	// stage 2: widen by one bit, form shifted edges and the intersection
	// ------------------------------------------------------------------------
	crdx_t cl_x, ct_x, cr_x, cb_x, tl_x, tt_x, tr_x, tb_x;

	assign cl_x = {cl_s1[W-1], cl_s1};
	assign ct_x = {ct_s1[W-1], ct_s1};
	assign cr_x = {cr_s1[W-1], cr_s1};
	assign cb_x = {cb_s1[W-1], cb_s1};
	assign tl_x = {tl_s1[W-1], tl_s1};
	assign tt_x = {tt_s1[W-1], tt_s1};
	assign tr_x = {tr_s1[W-1], tr_s1};
	assign tb_x = {tb_s1[W-1], tb_s1};

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			cl_s2   <= cl_x;
			ct_s2   <= ct_x;
			cr_s2   <= cr_x;
			cb_s2   <= cb_x;
			tl_s2   <= tl_x;
			tt_s2   <= tt_x;
			tr_s2   <= tr_x;
			tb_s2   <= tb_x;
			ctm1_s2 <= ct_x - crdx_t'(1);
			cbp1_s2 <= cb_x + crdx_t'(1);
			clm1_s2 <= cl_x - crdx_t'(1);
			crp1_s2 <= cr_x + crdx_t'(1);
			xl_s2   <= (cl_x > tl_x) ? cl_x : tl_x;
			xt_s2   <= (ct_x > tt_x) ? ct_x : tt_x;
			xr_s2   <= (cr_x < tr_x) ? cr_x : tr_x;
			xb_s2   <= (cb_x < tb_x) ? cb_x : tb_x;
		end
	end

	// ------------------------------------------------------------------------
	// stage 3: emptiness tests
	// ------------------------------------------------------------------------
	logic        cut_empty, tgt_empty, x_empty, rows_ok;
	strip_mask_t keep_w;

	always_comb begin
		cut_empty = (cl_s2 > cr_s2) || (ct_s2 > cb_s2);
		tgt_empty = (tl_s2 > tr_s2) || (tt_s2 > tb_s2);
		x_empty   = (xl_s2 > xr_s2) || (xt_s2 > xb_s2);
		rows_ok   = (xt_s2 <= xb_s2);
		keep_w[STRIP_TOP]    = (tl_s2 <= tr_s2) && (tt_s2 <= ctm1_s2);
		keep_w[STRIP_LEFT]   = (tl_s2 <= clm1_s2) && rows_ok;
		keep_w[STRIP_BOTTOM] = (tl_s2 <= tr_s2) && (cbp1_s2 <= tb_s2);
		keep_w[STRIP_RIGHT]  = (crp1_s2 <= tr_s2) && rows_ok;
	end

	// bounds of any emitted strip lie inside the target, so narrowing is exact
	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			pass_s3 <= cut_empty || tgt_empty || x_empty;
			keep_s3 <= keep_w;
			tl_s3   <= tl_s2[W-1:0];
			tt_s3   <= tt_s2[W-1:0];
			tr_s3   <= tr_s2[W-1:0];
			tb_s3   <= tb_s2[W-1:0];
			ctm1_s3 <= ctm1_s2[W-1:0];
			cbp1_s3 <= cbp1_s2[W-1:0];
			clm1_s3 <= clm1_s2[W-1:0];
			crp1_s3 <= crp1_s2[W-1:0];
			xt_s3   <= xt_s2[W-1:0];
			xb_s3   <= xb_s2[W-1:0];
		end
	end

	// ------------------------------------------------------------------------
	// piece serializer: one pending strip leaves per transaction
	// ------------------------------------------------------------------------
	logic load_w;
	logic none_w;

	assign load_w = ser_rdy && vld_s3;
	assign none_w = !pass_s3 && (keep_s3 == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			mask_q    <= '0;
		end else begin
			if (load_w) begin
				ser_vld_q <= 1'b1;
				mask_q    <= (pass_s3 || none_w) ? strip_mask_t'(1) : keep_s3;
			end else if (ser_vld_q && pieces.ready) begin
				// drop the strip just sent; last one empties the serializer
				ser_vld_q <= !last_w;
				mask_q    <= mask_q & (mask_q - strip_mask_t'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_w) begin
			pass_q <= pass_s3;
			none_q <= none_w;
			tl_q   <= tl_s3;
			tt_q   <= tt_s3;
			tr_q   <= tr_s3;
			tb_q   <= tb_s3;
			ctm1_q <= ctm1_s3;
			cbp1_q <= cbp1_s3;
			clm1_q <= clm1_s3;
			crp1_q <= crp1_s3;
			xt_q   <= xt_s3;
			xb_q   <= xb_s3;
		end
	end

	// lowest pending strip goes first
	always_comb begin
		priority if (mask_q[STRIP_TOP])    sel_w = STRIP_TOP;
		else if (mask_q[STRIP_LEFT])       sel_w = STRIP_LEFT;
		else if (mask_q[STRIP_BOTTOM])     sel_w = STRIP_BOTTOM;
		else                               sel_w = STRIP_RIGHT;
	end

	assign last_w = ((mask_q & (mask_q - strip_mask_t'(1))) == '0);

	// piece bounds for the selected strip
	crd_t pl_w, pt_w, pr_w, pb_w;

	always_comb begin
		pl_w = tl_q;
		pt_w = tt_q;
		pr_w = tr_q;
		pb_w = tb_q;
		if (none_q) begin
			pl_w = '0;
			pt_w = '0;
			pr_w = '0;
			pb_w = '0;
		end else if (!pass_q) begin
			unique case (sel_w)
				STRIP_TOP: begin
					pb_w = ctm1_q;
				end
				STRIP_LEFT: begin
					pt_w = xt_q;
					pr_w = clm1_q;
					pb_w = xb_q;
				end
				STRIP_BOTTOM: begin
					pt_w = cbp1_q;
				end
				STRIP_RIGHT: begin
					pl_w = crp1_q;
					pt_w = xt_q;
					pb_w = xb_q;
				end
				default: begin
					pl_w = tl_q;
				end
			endcase
		end
	end

	assign pieces.valid        = ser_vld_q;
	assign pieces.piece_left   = pl_w;
	assign pieces.piece_top    = pt_w;
	assign pieces.piece_right  = pr_w;
	assign pieces.piece_bottom = pb_w;
	assign pieces.piece_valid  = !none_q;
	assign pieces.last_piece   = last_w;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	`RSUB_ASSERT_NOW(a_pending_nonzero, clk, arst_n, ser_vld_q, mask_q != '0)
	`RSUB_ASSERT_NOW(a_pass_none_excl, clk, arst_n, ser_vld_q, !(pass_q && none_q))
	`RSUB_ASSERT_NOW(a_empty_is_last, clk, arst_n, pieces.valid && !pieces.piece_valid, pieces.last_piece)
	`RSUB_ASSERT_NEXT(a_more_pieces, clk, arst_n, pieces.valid && pieces.ready && !pieces.last_piece, pieces.valid)

endmodule

// ----- test/rsub_piece_check.sv -----
// ----------------------------------------------------------------------------
// rsub_piece_check
// watches both channels of the rectangle subtract block, works out the
// remaining pieces of every accepted rectangle pair and compares them in
// order with the pieces the block hands out
// ----------------------------------------------------------------------------
module rsub_piece_check #(
	parameter int COORD_WIDTH = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	rsub_rect_if  rects,
	rsub_piece_if pieces,
	output int    error_count,
	output int    pending_count
);
	import rsub_pkg::*;

	// one extra bit so that bound +1 and -1 never wrap
	typedef logic signed [COORD_WIDTH:0]   wide_t;
	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct {
		wide_t left;
		wide_t top;
		wide_t right;
		wide_t bottom;
	} box_t;

	typedef struct packed {
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
		logic   present;
		logic   last;
	} piece_t;

	piece_t piece_q[$];
	int     mismatches = 0;
	int     waiting = 0;

	assign error_count   = mismatches;
	assign pending_count = waiting;

	function automatic bit box_is_empty(box_t b);
		return (b.left > b.right) || (b.top > b.bottom);
	endfunction

	function automatic wide_t wmax(wide_t a, wide_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic wide_t wmin(wide_t a, wide_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic box_t widen(coord_t l, coord_t t, coord_t r, coord_t b);
		box_t w;
		w.left   = wide_t'(l);
		w.top    = wide_t'(t);
		w.right  = wide_t'(r);
		w.bottom = wide_t'(b);
		return w;
	endfunction

	function automatic piece_t as_piece(box_t b, logic present);
		piece_t p;
		p.left    = b.left[COORD_WIDTH-1:0];
		p.top     = b.top[COORD_WIDTH-1:0];
		p.right   = b.right[COORD_WIDTH-1:0];
		p.bottom  = b.bottom[COORD_WIDTH-1:0];
		p.present = present;
		p.last    = 1'b0;
		return p;
	endfunction

	// queue up the remaining pieces of target once cut is taken out
	function automatic void predict_pieces(box_t cut, box_t target);
		box_t   overlap;
		box_t   strip [NUM_STRIPS];
		box_t   nothing;
		piece_t p;
		int     found;

		overlap.left   = wmax(cut.left, target.left);
		overlap.top    = wmax(cut.top, target.top);
		overlap.right  = wmin(cut.right, target.right);
		overlap.bottom = wmin(cut.bottom, target.bottom);

		// empty operand or no overlap: the target passes through whole
		if (box_is_empty(cut) || box_is_empty(target) || box_is_empty(overlap)) begin
			p = as_piece(target, 1'b1);
			p.last = 1'b1;
			piece_q.push_back(p);
			return;
		end

		strip[STRIP_TOP]    = '{target.left, target.top, target.right,
			cut.top - wide_t'(1)};
		strip[STRIP_LEFT]   = '{target.left, overlap.top, cut.left - wide_t'(1),
			overlap.bottom};
		strip[STRIP_BOTTOM] = '{target.left, cut.bottom + wide_t'(1), target.right,
			target.bottom};
		strip[STRIP_RIGHT]  = '{cut.right + wide_t'(1), overlap.top, target.right,
			overlap.bottom};

		found = 0;
		for (int i = 0; i < NUM_STRIPS; i++) begin
			if (!box_is_empty(strip[i])) begin
				piece_q.push_back(as_piece(strip[i], 1'b1));
				found++;
			end
		end

		// cut swallows the target: a single empty marker
		if (found == 0) begin
			nothing = '{'0, '0, '0, '0};
			piece_q.push_back(as_piece(nothing, 1'b0));
		end
		piece_q[piece_q.size()-1].last = 1'b1;
	endfunction

	// compare every piece transaction, then predict every rectangle transaction
	always @(posedge clk) begin
		piece_t want;
		if (arst_n) begin
			if (pieces.valid && pieces.ready) begin
				if (piece_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected piece, expected none, actual l=%0d t=%0d r=%0d b=%0d valid=%0b last=%0b",
						$time, pieces.piece_left, pieces.piece_top, pieces.piece_right,
						pieces.piece_bottom, pieces.piece_valid, pieces.last_piece);
				end else begin
					want = piece_q.pop_front();
					if (pieces.piece_left !== want.left || pieces.piece_top !== want.top ||
						pieces.piece_right !== want.right || pieces.piece_bottom !== want.bottom ||
						pieces.piece_valid !== want.present || pieces.last_piece !== want.last) begin
						mismatches++;
						$display("%0t: piece mismatch, expected l=%0d t=%0d r=%0d b=%0d valid=%0b last=%0b",
							$time, want.left, want.top, want.right, want.bottom,
							want.present, want.last);
						$display("%0t: piece mismatch, actual   l=%0d t=%0d r=%0d b=%0d valid=%0b last=%0b",
							$time, pieces.piece_left, pieces.piece_top, pieces.piece_right,
							pieces.piece_bottom, pieces.piece_valid, pieces.last_piece);
					end
				end
			end
			if (rects.valid && rects.ready) begin
				predict_pieces(
					widen(rects.cut_left, rects.cut_top, rects.cut_right, rects.cut_bottom),
					widen(rects.target_left, rects.target_top, rects.target_right,
						rects.target_bottom));
			end
			waiting = piece_q.size();
		end
	end

endmodule

// ----- test/rectangle_subtract_top_tb.sv -----
// ----------------------------------------------------------------------------
// rectangle_subtract_top_tb
// drives rectangle pairs into the rectangle subtract block: a directed set of
// corner cases, then random pairs biased toward overlapping rectangles, with
// random gaps on the input and random stalls on the piece output; the piece
// checker beside the block reports the errors it finds
// ----------------------------------------------------------------------------
module rectangle_subtract_top_tb;

	localparam int COORD_WIDTH = 16;
	localparam int MIN_C = -32768;
	localparam int MAX_C = 32767;
	localparam int RANDOM_PAIRS = 288;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef struct packed {
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
	} rect_t;

	logic clk;
	logic arst_n;
	int   error_count;
	int   outstanding;
	int   pairs_sent = 0;

	rsub_rect_if  #(.COORD_WIDTH(COORD_WIDTH)) rects_ch ();
	rsub_piece_if #(.COORD_WIDTH(COORD_WIDTH)) pieces_ch ();

	rectangle_subtract_top #(.COORD_WIDTH(COORD_WIDTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rects  (rects_ch),
		.pieces (pieces_ch)
	);

	rsub_piece_check #(.COORD_WIDTH(COORD_WIDTH)) u_piece_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.rects         (rects_ch),
		.pieces        (pieces_ch),
		.error_count   (error_count),
		.pending_count (outstanding)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic rect_t mk_rect(int l, int t, int r, int b);
		return '{coord_t'(l), coord_t'(t), coord_t'(r), coord_t'(b)};
	endfunction

	// rectangle with corners in base..base+span, ordered unless told otherwise
	function automatic rect_t rand_rect_in(int base, int span, bit ordered);
		int x0, x1, y0, y1, tmp;
		x0 = base + $urandom_range(0, span);
		x1 = base + $urandom_range(0, span);
		y0 = base + $urandom_range(0, span);
		y1 = base + $urandom_range(0, span);
		if (ordered && x0 > x1) begin
			tmp = x0; x0 = x1; x1 = tmp;
		end
		if (ordered && y0 > y1) begin
			tmp = y0; y0 = y1; y1 = tmp;
		end
		return mk_rect(x0, y0, x1, y1);
	endfunction

	// one rectangle pair transaction, valid stays up across back-to-back pairs
	task automatic send_pair(input rect_t cut, input rect_t target);
		int gap;
		gap = pick_gap();
		if (pairs_sent % 64 < 12)
			gap = 0;
		if (gap > 0) begin
			rects_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rects_ch.valid         <= 1'b1;
		rects_ch.cut_left      <= cut.left;
		rects_ch.cut_top       <= cut.top;
		rects_ch.cut_right     <= cut.right;
		rects_ch.cut_bottom    <= cut.bottom;
		rects_ch.target_left   <= target.left;
		rects_ch.target_top    <= target.top;
		rects_ch.target_right  <= target.right;
		rects_ch.target_bottom <= target.bottom;
		do @(posedge clk); while (!rects_ch.ready);
		pairs_sent++;
	endtask

	// piece receiver: random stalls, quiet stretches and one long hold-off
	initial begin
		int rx_cycle;
		int stall_left;
		pieces_ch.ready = 1'b0;
		rx_cycle = 0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle == 300) begin
				// hold off long enough for the block to back up into its input
				pieces_ch.ready <= 1'b0;
				repeat (250) @(posedge clk);
			end else if (stall_left > 0) begin
				pieces_ch.ready <= 1'b0;
				stall_left--;
			end else if ((rx_cycle / 128) % 4 != 1 && $urandom_range(0, 3) == 0) begin
				pieces_ch.ready <= 1'b0;
				stall_left = pick_gap();
			end else begin
				pieces_ch.ready <= 1'b1;
			end
		end
	end

	// reset and stimulus
	initial begin
		rect_t full;
		rect_t cut;
		rect_t target;
		int    sel;
		int    span;
		int    base;
		bit    ordered;

		arst_n                 = 1'b0;
		rects_ch.valid         = 1'b0;
		rects_ch.cut_left      = '0;
		rects_ch.cut_top       = '0;
		rects_ch.cut_right     = '0;
		rects_ch.cut_bottom    = '0;
		rects_ch.target_left   = '0;
		rects_ch.target_top    = '0;
		rects_ch.target_right  = '0;
		rects_ch.target_bottom = '0;
		full = mk_rect(MIN_C, MIN_C, MAX_C, MAX_C);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// cut strictly inside: all four strips
		send_pair(mk_rect(10, 10, 20, 20), mk_rect(0, 0, 30, 30));
		// nothing remains: identical and covering cut
		send_pair(mk_rect(0, 0, 30, 30), mk_rect(0, 0, 30, 30));
		send_pair(mk_rect(-5, -5, 40, 40), mk_rect(0, 0, 30, 30));
		// one strip each: top, left, bottom, right
		send_pair(mk_rect(-5, 10, 40, 40), mk_rect(0, 0, 30, 30));
		send_pair(mk_rect(10, -5, 40, 40), mk_rect(0, 0, 30, 30));
		send_pair(mk_rect(-5, -5, 40, 20), mk_rect(0, 0, 30, 30));
		send_pair(mk_rect(-5, -5, 20, 40), mk_rect(0, 0, 30, 30));
		// one-column right strip
		send_pair(mk_rect(-5, -5, 29, 40), mk_rect(0, 0, 30, 30));
		// no overlap: touching edge and off the corner
		send_pair(mk_rect(31, 0, 40, 30), mk_rect(0, 0, 30, 30));
		send_pair(mk_rect(-10, -10, -1, -1), mk_rect(0, 0, 30, 30));
		// empty cut in either direction
		send_pair(mk_rect(20, 10, 10, 20), mk_rect(0, 0, 30, 30));
		send_pair(mk_rect(10, 20, 20, 10), mk_rect(0, 0, 30, 30));
		// empty target still goes out as a valid piece
		send_pair(mk_rect(0, 0, 30, 30), mk_rect(25, 5, 5, 25));
		send_pair(mk_rect(9, 9, 1, 1), mk_rect(3, 7, 2, 0));
		// full-range target, single-point cut at each extreme corner
		send_pair(mk_rect(MIN_C, MIN_C, MIN_C, MIN_C), full);
		send_pair(mk_rect(MAX_C, MAX_C, MAX_C, MAX_C), full);
		// full range on both sides, and a point target under a full cut
		send_pair(full, full);
		send_pair(full, mk_rect(MIN_C, MIN_C, MIN_C, MIN_C));
		// bounds at both ends of the range: bottom strip and left strip past the edge
		send_pair(mk_rect(0, MAX_C - 5, 5, MAX_C), mk_rect(-10, MAX_C - 10, 10, MAX_C));
		send_pair(mk_rect(MIN_C, 0, MIN_C + 3, 5), mk_rect(MIN_C, -5, MIN_C + 10, 10));
		// alternating bit patterns in the strips
		send_pair(mk_rect(-21846, -21846, 21845, 21845), full);
		send_pair(mk_rect(21845, -21846, 21845, 21845), mk_rect(-21846, -21846, MAX_C, MAX_C));

		// random pairs, most of them overlapping in a small window
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			sel = $urandom_range(0, 99);
			ordered = ($urandom_range(0, 9) != 0);
			case ($urandom_range(0, 2))
				0: span = 3;
				1: span = 15;
				default: span = 63;
			endcase
			if (sel < 55) begin
				base = int'($urandom_range(0, 65535 - span)) + MIN_C;
				target = rand_rect_in(base, span, ordered);
				cut = rand_rect_in(base, span, ordered);
			end else if (sel < 70) begin
				base = $urandom_range(0, 1) ? MIN_C : MAX_C - span;
				target = rand_rect_in(base, span, ordered);
				cut = rand_rect_in(base, span, ordered);
			end else if (sel < 85) begin
				target = rand_rect_in(MIN_C, 65535, 1'b1);
				cut = rand_rect_in(MIN_C, 65535, 1'b1);
			end else begin
				target = rand_rect_in(MIN_C, 65535, 1'b0);
				cut = rand_rect_in(MIN_C, 65535, 1'b0);
			end
			send_pair(cut, target);
		end

		// drain and settle
		rects_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
